// ===== src/ps2_mouse_packet_decoder_unit_macros.svh =====
// Assertion macros shared by the mouse packet decoder RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef PS2_MOUSE_PACKET_DECODER_UNIT_MACROS_SVH
`define PS2_MOUSE_PACKET_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PMD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pmd assertion failed");

// Next-cycle implication, checked out of reset.
`define PMD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pmd assertion failed");

`endif

// ===== src/pmd_pkg.sv =====
// Package for the mouse packet decoder: register indexes, reset values,
// event codes and the structs passed between the decoder modules. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pmd_pkg;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_WHEEL_MODE = 2'd0;
   localparam logic [1:0] CSR_X_MAX      = 2'd1;
   localparam logic [1:0] CSR_Y_MAX      = 2'd2;

   // Register and state reset values
   localparam logic [11:0] X_MAX_RESET = 12'd1023;
   localparam logic [11:0] Y_MAX_RESET = 12'd767;
   localparam logic [11:0] POS_X_RESET = 12'd512;
   localparam logic [11:0] POS_Y_RESET = 12'd384;

   // Last byte index of a packet
   localparam logic [1:0] LAST_IDX_STD   = 2'd2;
   localparam logic [1:0] LAST_IDX_WHEEL = 2'd3;

   // Button numbers reported with press and release
   localparam logic [2:0] BUTTON_ONE = 3'd1;
   localparam logic [2:0] BUTTON_TWO = 3'd2;

   // Event codes
   typedef enum logic [1:0] {
      KIND_MOVE    = 2'd0,
      KIND_PRESS   = 2'd1,
      KIND_RELEASE = 2'd2,
      KIND_SCROLL  = 2'd3
   } kind_type;

   // Configuration registers
   typedef struct packed {
      logic        wheel_mode;
      logic [11:0] x_max;
      logic [11:0] y_max;
   } cfg_type;

   // Pending events of one packet, in emit order
   typedef struct packed {
      logic move;
      logic btn1;
      logic btn2;
      logic scroll;
   } ev_mask_type;

   // One decoded packet
   typedef struct packed {
      ev_mask_type        mask;
      logic [2:0]         buttons;
      logic signed [7:0]  dx;
      logic signed [7:0]  dy;
      logic [11:0]        pos_x;
      logic [11:0]        pos_y;
      logic signed [3:0]  scroll;
      logic               btn1_press;
      logic               btn2_press;
   } pkt_type;

endpackage

`default_nettype wire

// ===== src/pmd_req_if.sv =====
// Byte channel into the mouse packet decoder: valid, ready and one data byte.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface pmd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// ===== src/pmd_rsp_if.sv =====
// Event channel out of the mouse packet decoder: valid, ready and one event.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface pmd_rsp_if;
   logic              valid;
   logic              ready;
   logic [1:0]        event_kind;
   logic signed [7:0] delta_x;
   logic signed [7:0] delta_y;
   logic [11:0]       pos_x_out;
   logic [11:0]       pos_y_out;
   logic [2:0]        button_info;
   logic signed [3:0] scroll_step;
   logic              last_event;

   modport source (output valid, output event_kind, output delta_x, output delta_y,
                   output pos_x_out, output pos_y_out, output button_info,
                   output scroll_step, output last_event, input ready);
   modport sink   (input valid, input event_kind, input delta_x, input delta_y,
                   input pos_x_out, input pos_y_out, input button_info,
                   input scroll_step, input last_event, output ready);
endinterface

`default_nettype wire

// ===== src/pmd_assembler.sv =====
// Packet assembler: gathers bytes, decodes the completed packet, tracks
// position and buttons. Depends on pmd_pkg, pmd_req_if and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "ps2_mouse_packet_decoder_unit_macros.svh"

module pmd_assembler import pmd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   pmd_req_if.sink req,
   input  logic    pkt_ready,
   output logic    pkt_load,
   output pkt_type pkt
);

   logic [1:0]  byte_index_ff, byte_index_in;
   logic [7:0]  held0_ff, held1_ff, held2_ff;
   logic [11:0] pos_x_ff, pos_x_in;
   logic [11:0] pos_y_ff, pos_y_in;
   logic [1:0]  prev_buttons_ff, prev_buttons_in;

   logic              complete;
   logic              accept;
   logic [7:0]        b2;
   logic [7:0]        neg_b2;
   logic signed [13:0] sum_x;
   logic signed [13:0] sum_y;
   logic [2:0]        buttons;
   logic signed [3:0] scroll;

   // A byte at or past the last index of the current mode closes the packet
   assign complete  = byte_index_ff >= (cfg.wheel_mode ? LAST_IDX_WHEEL : LAST_IDX_STD);
   assign req.ready = !complete || pkt_ready;
   assign accept    = req.valid && req.ready;
   assign pkt_load  = accept && complete;

   // Decode the packet from held bytes and the closing byte
   assign b2      = cfg.wheel_mode ? held2_ff : req.data_byte;
   assign neg_b2  = 8'(8'd0 - b2);
   assign buttons = held0_ff[2:0];
   assign scroll  = cfg.wheel_mode ? $signed(req.data_byte[3:0]) : 4'sd0;
   assign sum_x   = $signed({2'b00, pos_x_ff}) + $signed({{6{held1_ff[7]}}, held1_ff});
   assign sum_y   = $signed({2'b00, pos_y_ff}) + $signed({{6{neg_b2[7]}}, neg_b2});

   // Clamp the new position to 0..max
   always_comb begin
      if (sum_x[13]) begin
         pos_x_in = 12'd0;
      end else if (sum_x[12:0] > {1'b0, cfg.x_max}) begin
         pos_x_in = cfg.x_max;
      end else begin
         pos_x_in = sum_x[11:0];
      end
      if (sum_y[13]) begin
         pos_y_in = 12'd0;
      end else if (sum_y[12:0] > {1'b0, cfg.y_max}) begin
         pos_y_in = cfg.y_max;
      end else begin
         pos_y_in = sum_y[11:0];
      end
   end

   // Build the event set
   always_comb begin
      pkt.buttons     = buttons;
      pkt.dx          = $signed(held1_ff);
      pkt.dy          = $signed(neg_b2);
      pkt.pos_x       = pos_x_in;
      pkt.pos_y       = pos_y_in;
      pkt.scroll      = scroll;
      pkt.btn1_press  = buttons[0];
      pkt.btn2_press  = buttons[1];
      pkt.mask.move   = (held1_ff != 8'd0) || (b2 != 8'd0);
      pkt.mask.btn1   = buttons[0] ^ prev_buttons_ff[0];
      pkt.mask.btn2   = buttons[1] ^ prev_buttons_ff[1];
      pkt.mask.scroll = scroll != 4'sd0;
   end

   // Advance the byte index, reset to zero on a closing byte
   always_comb begin
      byte_index_in   = byte_index_ff;
      prev_buttons_in = prev_buttons_ff;
      if (accept) begin
         if (complete) begin
            byte_index_in   = 2'd0;
            prev_buttons_in = buttons[1:0];
         end else begin
            byte_index_in = 2'(byte_index_ff + 2'd1);
         end
      end
   end

   // Hold control state and position
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff   <= 2'd0;
         pos_x_ff        <= POS_X_RESET;
         pos_y_ff        <= POS_Y_RESET;
         prev_buttons_ff <= 2'd0;
      end else begin
         byte_index_ff   <= byte_index_in;
         prev_buttons_ff <= prev_buttons_in;
         if (pkt_load) begin
            pos_x_ff <= pos_x_in;
            pos_y_ff <= pos_y_in;
         end
      end
   end

   // Store the early bytes of the packet
   always_ff @(posedge clock) begin
      if (accept && !complete) begin
         case (byte_index_ff)
            2'd0:    held0_ff <= req.data_byte;
            2'd1:    held1_ff <= req.data_byte;
            default: held2_ff <= req.data_byte;
         endcase
      end
   end

   `PMD_ASSERT_NEXT(a_close_clears_index, clock, reset, pkt_load, byte_index_ff == 2'd0)
   `PMD_ASSERT_NEXT(a_store_advances, clock, reset, accept && !complete, byte_index_ff != 2'd0)
   `PMD_ASSERT_IMP(a_close_needs_slot, clock, reset, pkt_load, pkt_ready)

endmodule

`default_nettype wire

// ===== src/pmd_event_drain.sv =====
// Event drain: holds one decoded packet and emits its events into the result register
// one beat per cycle unless rsp stalls. Depends on pmd_pkg, pmd_rsp_if, macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "ps2_mouse_packet_decoder_unit_macros.svh"

module pmd_event_drain import pmd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      pkt_load,
   input  pkt_type   pkt,
   output logic      pkt_ready,
   pmd_rsp_if.source rsp
);

   pkt_type     pkt_ff;
   ev_mask_type mask_ff, mask_in;

   logic              rsp_valid_ff;
   kind_type          kind_ff, kind_in;
   logic signed [7:0] dx_ff, dx_in;
   logic signed [7:0] dy_ff, dy_in;
   logic [11:0]       pos_x_ff;
   logic [11:0]       pos_y_ff;
   logic [2:0]        info_ff, info_in;
   logic signed [3:0] scroll_ff, scroll_in;
   logic              last_ff;
   logic              advance;
   logic              emit;

   assign pkt_ready = mask_ff == '0;
   assign advance   = !rsp_valid_ff || rsp.ready;
   assign emit      = advance && (mask_ff != '0);

   // Pick the first pending event and drop it from the mask
   always_comb begin
      mask_in   = mask_ff;
      kind_in   = KIND_MOVE;
      dx_in     = 8'sd0;
      dy_in     = 8'sd0;
      info_in   = pkt_ff.buttons;
      scroll_in = 4'sd0;
      if (mask_ff.move) begin
         mask_in.move = 1'b0;
         dx_in        = pkt_ff.dx;
         dy_in        = pkt_ff.dy;
      end else if (mask_ff.btn1) begin
         mask_in.btn1 = 1'b0;
         kind_in      = pkt_ff.btn1_press ? KIND_PRESS : KIND_RELEASE;
         info_in      = BUTTON_ONE;
      end else if (mask_ff.btn2) begin
         mask_in.btn2 = 1'b0;
         kind_in      = pkt_ff.btn2_press ? KIND_PRESS : KIND_RELEASE;
         info_in      = BUTTON_TWO;
      end else begin
         mask_in.scroll = 1'b0;
         kind_in        = KIND_SCROLL;
         scroll_in      = pkt_ff.scroll;
      end
   end

   // Hold the packet and pending mask
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (pkt_load) begin
         mask_ff <= pkt.mask;
      end else if (emit) begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pkt_load) begin
         pkt_ff <= pkt;
      end
   end

   // Result register: load a beat when empty or taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff   <= kind_in;
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         pos_x_ff  <= pkt_ff.pos_x;
         pos_y_ff  <= pkt_ff.pos_y;
         info_ff   <= info_in;
         scroll_ff <= scroll_in;
         last_ff   <= mask_in == '0;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.event_kind  = kind_ff;
   assign rsp.delta_x     = dx_ff;
   assign rsp.delta_y     = dy_ff;
   assign rsp.pos_x_out   = pos_x_ff;
   assign rsp.pos_y_out   = pos_y_ff;
   assign rsp.button_info = info_ff;
   assign rsp.scroll_step = scroll_ff;
   assign rsp.last_event  = last_ff;

   `PMD_ASSERT_IMP(a_load_into_empty, clock, reset, pkt_load, mask_ff == '0)
   `PMD_ASSERT_IMP(a_more_after_not_last, clock, reset, rsp_valid_ff && !last_ff,
                   mask_ff != '0)
   `PMD_ASSERT_NEXT(a_empty_stays, clock, reset, (mask_ff == '0) && !pkt_load,
                    mask_ff == '0)

endmodule

`default_nettype wire

// ===== src/ps2_mouse_packet_decoder_unit.sv =====
// A closing byte loads its packet into the drain's packet and mask registers; each
// event then enters the result register, one per cycle while the sink takes
// them. Throughput: one byte per cycle; a closing byte waits only while the previous
// packet still has events held in the drain stage (at most four, one per cycle).
// Reset is synchronous and active high: byte index 0, position (512, 384), buttons
// released, three-byte mode, clamp bounds 1023 and 767.
`timescale 1ns / 1ps
`default_nettype none

module ps2_mouse_packet_decoder_unit import pmd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   pmd_req_if.sink     req_bus,
   pmd_rsp_if.source   rsp_bus,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata
);

   cfg_type cfg_ff;
   logic    pkt_load;
   logic    pkt_ready;
   pkt_type pkt;

   // Configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wheel_mode <= 1'b0;
         cfg_ff.x_max      <= X_MAX_RESET;
         cfg_ff.y_max      <= Y_MAX_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WHEEL_MODE: cfg_ff.wheel_mode <= csr_wdata[0];
            CSR_X_MAX:      cfg_ff.x_max      <= csr_wdata;
            CSR_Y_MAX:      cfg_ff.y_max      <= csr_wdata;
            default:        ;
         endcase
      end
   end

   pmd_assembler u_assembler (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req       (req_bus),
      .pkt_ready (pkt_ready),
      .pkt_load  (pkt_load),
      .pkt       (pkt)
   );

   pmd_event_drain u_drain (
      .clock     (clock),
      .reset     (reset),
      .pkt_load  (pkt_load),
      .pkt       (pkt),
      .pkt_ready (pkt_ready),
      .rsp       (rsp_bus)
   );

endmodule

`default_nettype wire
